/* src/assert_macros.svh */
// assertion macros shared by the blur modules
// expects signals named clk and rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication on the next cycle
`define CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// invariant
`define CHK_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

/* src/bb3_pkg.sv */
// types, constants and the reciprocal table for the 3x3 box blur
// no dependencies
`default_nettype none

package bb3_pkg;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int FW_W    = 11;
  localparam int FH_W    = 12;
  localparam int ROW_W   = FH_W + 1;
  localparam int SUM_W   = 12;
  localparam int NUM_W   = SUM_W + 1;
  localparam int N_W     = 4;
  localparam int D_W     = N_W + 1;
  localparam int REC_W   = 16;
  localparam int PROD_W  = NUM_W + REC_W;
  localparam int RP_W    = NUM_W + D_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [FW_W-1:0] RST_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0] RST_HEIGHT = FH_W'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_MUL,
    S_CORR
  } state_t;

  typedef struct packed {
    logic take;
    logic step_in;
    logic sum_en;
    logic mul_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_frame;
    logic prefill;
    logic out_free;
  } stat_t;

  // floor(2^16 / (2n)) for the neighbour counts that occur
  function automatic logic [REC_W-1:0] recip(input logic [N_W-1:0] n);
    logic [REC_W-1:0] m;
    case (n)
      N_W'(1): m = REC_W'(32768);
      N_W'(2): m = REC_W'(16384);
      N_W'(3): m = REC_W'(10922);
      N_W'(4): m = REC_W'(8192);
      N_W'(6): m = REC_W'(5461);
      N_W'(9): m = REC_W'(3640);
      default: m = REC_W'(32768);
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* src/bb3_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/bb3_cfg.sv */
// apb register file: frame width and frame height
// depends on bb3_pkg
`default_nettype none

module bb3_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0]   paddr,
  input  logic [bb3_pkg::PDATA_W-1:0]   pwdata,
  output logic [bb3_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [bb3_pkg::FW_W-1:0]      fw,
  output logic [bb3_pkg::FH_W-1:0]      fh,
  output logic                          restart
);

  import bb3_pkg::*;

  reg_t sel;

  assign pready  = 1'b1;
  assign sel     = reg_t'(paddr[2]);
  assign restart = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= RST_WIDTH;
      fh <= RST_HEIGHT;
    end else if (restart) begin
      case (sel)
        REG_WIDTH:  fw <= pwdata[FW_W-1:0];
        REG_HEIGHT: fh <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_WIDTH:  prdata = PDATA_W'(fw);
      REG_HEIGHT: prdata = PDATA_W'(fh);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/bb3_ctrl.sv */
// controller state machine: sequences one word through read, sum, scale, correct
// depends on bb3_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bb3_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            mode,
  output logic            in_ready,
  input  bb3_pkg::stat_t  st,
  output bb3_pkg::cmd_t   cmd
);

  import bb3_pkg::*;

  state_t state;
  state_t state_next;
  logic   take_ok;

  // a flush inside the frame is taken and dropped
  assign take_ok = in_valid && !(st.in_frame && mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take_ok) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = st.prefill ? S_IDLE : S_SUM;
      end
      S_SUM:  state_next = S_MUL;
      S_MUL:  state_next = S_CORR;
      S_CORR: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = take_ok;
      end
      S_READ: cmd.step_in  = 1'b1;
      S_SUM:  cmd.sum_en   = 1'b1;
      S_MUL:  cmd.mul_en   = 1'b1;
      S_CORR: cmd.load_out = st.out_free;
      default: ;
    endcase
  end

  `CHK_NXT(read_leaves, state == S_READ, state == S_IDLE || state == S_SUM)
  `CHK_NXT(take_reads, cmd.take, state == S_READ)

endmodule

`default_nettype wire

/* src/bb3_dp.sv */
// datapath: position counters, line stores, 3x3 window, averaging and output register
// depends on bb3_pkg, bb3_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bb3_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bb3_pkg::FW_W-1:0]    fw,
  input  logic [bb3_pkg::FH_W-1:0]    fh,
  input  logic                        restart,
  input  bb3_pkg::cmd_t               cmd,
  output bb3_pkg::stat_t              st,
  input  logic [bb3_pkg::CH_W-1:0]    red_in,
  input  logic [bb3_pkg::CH_W-1:0]    green_in,
  input  logic [bb3_pkg::CH_W-1:0]    blue_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bb3_pkg::CH_W-1:0]    red_out,
  output logic [bb3_pkg::CH_W-1:0]    green_out,
  output logic [bb3_pkg::CH_W-1:0]    blue_out,
  output logic                        frame_done
);

  import bb3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0]  ew;
  logic [FH_W-1:0]  eh;
  logic [FW_W-1:0]  ci;
  logic [ROW_W-1:0] ri;
  logic [FW_W-1:0]  co;
  logic [FH_W-1:0]  ro;
  logic             last_out;

  logic [PIX_W-1:0] px;
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;
  logic [PIX_W-1:0] win [3][3];

  logic [2:0]       col_ok;
  logic [2:0]       row_ok;
  logic [1:0]       cc;
  logic [1:0]       rc;
  logic [SUM_W-1:0] sum_c [3];
  logic [N_W-1:0]   n_c;
  logic [SUM_W-1:0] sum_q [3];
  logic [N_W-1:0]   n_q;

  logic [NUM_W-1:0]  num_c  [3];
  logic [PROD_W-1:0] prod_c [3];
  logic [NUM_W-1:0]  num_q  [3];
  logic [NUM_W-1:0]  q0_q   [3];
  logic [D_W-1:0]    d_q;

  logic [RP_W-1:0]  dprod [3];
  logic [RP_W-1:0]  rem   [3];
  logic [NUM_W-1:0] qf    [3];

  // effective frame size
  always_comb begin
    if (fw == '0) begin
      ew = FW_W'(1);
    end else if ({21'd0, fw} > 32'(MAX_WIDTH)) begin
      ew = FW_W'(MAX_WIDTH);
    end else begin
      ew = fw;
    end
    eh = (fh == '0) ? FH_W'(1) : fh;
  end

  assign last_out    = (ro == eh - FH_W'(1)) && (co == ew - FW_W'(1));
  assign st.in_frame = ri < ROW_W'(eh);
  assign st.prefill  = (ri == '0) || ((ri == ROW_W'(1)) && (ci == '0));
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ci <= '0;
      ri <= '0;
      co <= '0;
      ro <= '0;
    end else begin
      if (cmd.step_in) begin
        if (ci == ew - FW_W'(1)) begin
          ci <= '0;
          ri <= ri + ROW_W'(1);
        end else begin
          ci <= ci + FW_W'(1);
        end
      end
      if (cmd.load_out) begin
        if (last_out) begin
          ci <= '0;
          ri <= '0;
          co <= '0;
          ro <= '0;
        end else if (co == ew - FW_W'(1)) begin
          co <= '0;
          ro <= ro + FH_W'(1);
        end else begin
          co <= co + FW_W'(1);
        end
      end
    end
  end

  // beyond the frame the stores are fed zero
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px <= st.in_frame ? {red_in, green_in, blue_in} : '0;
    end
  end

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.step_in),
    .waddr (AW'(ci)),
    .wdata (mid_rd),
    .re    (cmd.take),
    .raddr (AW'(ci)),
    .rdata (up_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.step_in),
    .waddr (AW'(ci)),
    .wdata (px),
    .re    (cmd.take),
    .raddr (AW'(ci)),
    .rdata (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.step_in) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= up_rd;
      win[2][1] <= mid_rd;
      win[2][2] <= px;
    end
  end

  // in-frame neighbours of the output pixel
  always_comb begin
    col_ok[0] = co != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = (co + FW_W'(1)) < ew;
    row_ok[0] = ro != '0;
    row_ok[1] = 1'b1;
    row_ok[2] = (ro + FH_W'(1)) < eh;
    cc  = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[2]);
    rc  = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[2]);
    n_c = N_W'(cc) * N_W'(rc);
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (col_ok[c] && row_ok[r]) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(win[c][r][PIX_W-1-CH_W*ch -: CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_q <= sum_c;
      n_q   <= n_c;
    end
  end

  // (2*sum + n) / (2n): reciprocal estimate, then one correction step
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num_c[ch]  = {sum_q[ch], 1'b0} + NUM_W'(n_q);
      prod_c[ch] = PROD_W'(num_c[ch]) * PROD_W'(recip(n_q));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= num_c[ch];
        q0_q[ch]  <= prod_c[ch][PROD_W-1 -: NUM_W];
      end
      d_q <= {n_q, 1'b0};
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      dprod[ch] = RP_W'(q0_q[ch]) * RP_W'(d_q);
      rem[ch]   = RP_W'(num_q[ch]) - dprod[ch];
      qf[ch]    = (rem[ch] >= RP_W'(d_q)) ? q0_q[ch] + NUM_W'(1) : q0_q[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_out    <= qf[0][CH_W-1:0];
      green_out  <= qf[1][CH_W-1:0];
      blue_out   <= qf[2][CH_W-1:0];
      frame_done <= last_out;
    end
  end

  `CHK_ALW(col_in_range, ci < ew)
  `CHK_IMP(load_needs_room, cmd.load_out, !out_valid || out_ready)
  `CHK_NXT(frame_end_clears, cmd.load_out && last_out, ci == '0 && ri == '0 && co == '0 && ro == '0)

endmodule

`default_nettype wire

/* src/box_blur_3x3_edge_aware_top.sv */
// edge-aware 3x3 box blur, top level
// each word passes ram read, window, sum, reciprocal multiply and correction before
// the next word is taken; the word k+width+1 releases the result for pixel k;
// the first width+1 words stop after the window step, a dropped flush stays in idle
// reset: width 640, height 480, frame position and control cleared; line stores not cleared
// depends on bb3_pkg, bb3_cfg, bb3_ctrl, bb3_dp, bb3_ram
`default_nettype none

module box_blur_3x3_edge_aware_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0]   paddr,
  input  logic [bb3_pkg::PDATA_W-1:0]   pwdata,
  output logic [bb3_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [bb3_pkg::CH_W-1:0]      red_in,
  input  logic [bb3_pkg::CH_W-1:0]      green_in,
  input  logic [bb3_pkg::CH_W-1:0]      blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb3_pkg::CH_W-1:0]      red_out,
  output logic [bb3_pkg::CH_W-1:0]      green_out,
  output logic [bb3_pkg::CH_W-1:0]      blue_out,
  output logic                          frame_done
);

  import bb3_pkg::*;

  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;
  logic            restart;
  cmd_t            cmd;
  stat_t           st;

  bb3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fw      (fw),
    .fh      (fh),
    .restart (restart)
  );

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bb3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .fw         (fw),
    .fh         (fh),
    .restart    (restart),
    .cmd        (cmd),
    .st         (st),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_done (frame_done)
  );

endmodule

`default_nettype wire

/* bench/blur_checker.sv */
// checker for the 3x3 box blur: follows the register port and both word channels,
// predicts every blurred pixel and compares it field by field with the block's output
// depends on bb3_pkg
module blur_checker
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic [CH_W-1:0]    red_in,
  input  logic [CH_W-1:0]    green_in,
  input  logic [CH_W-1:0]    blue_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CH_W-1:0]    red_out,
  input  logic [CH_W-1:0]    green_out,
  input  logic [CH_W-1:0]    blue_out,
  input  logic               frame_done,
  output int                 fail_count,
  output int                 blurred_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            done;
  } blur_px_t;

  logic [FW_W-1:0]  frame_w;
  logic [FH_W-1:0]  frame_h;
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] mid_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      in_pos;
  int unsigned      out_pos;
  blur_px_t         mean_q [$];

  function automatic bit blur_step(input logic flush, input logic [PIX_W-1:0] pix_in,
                                   output blur_px_t res);
    int unsigned w, h, total, col, row, ocol, n, c, r, i;
    int unsigned sum [3];
    logic [PIX_W-1:0] pix, up_old, mid_old, v;
    w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
    h = (frame_h == 0) ? 1 : frame_h;
    total = w * h;
    pix = '0;
    res = '0;
    if (in_pos < total) begin
      if (flush) return 1'b0;
      pix = pix_in;
    end
    col = in_pos % w;
    up_old = upper_line[col];
    mid_old = mid_line[col];
    upper_line[col] = mid_old;
    mid_line[col] = pix;
    for (i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = up_old;
    win[7] = mid_old;
    win[8] = pix;
    in_pos++;
    if (in_pos < w + 2) return 1'b0;

    row = out_pos / w;
    ocol = out_pos % w;
    sum[0] = 0;
    sum[1] = 0;
    sum[2] = 0;
    n = 0;
    for (c = 0; c < 3; c++) begin
      if (c == 0 && ocol == 0) continue;
      if (c == 2 && ocol + 1 >= w) continue;
      for (r = 0; r < 3; r++) begin
        if (r == 0 && row == 0) continue;
        if (r == 2 && row + 1 >= h) continue;
        v = win[c*3 + r];
        sum[0] += v[23:16];
        sum[1] += v[15:8];
        sum[2] += v[7:0];
        n++;
      end
    end
    res.red   = CH_W'((2 * sum[0] + n) / (2 * n));
    res.green = CH_W'((2 * sum[1] + n) / (2 * n));
    res.blue  = CH_W'((2 * sum[2] + n) / (2 * n));
    if (out_pos + 1 >= total) begin
      res.done = 1'b1;
      in_pos = 0;
      out_pos = 0;
    end else begin
      out_pos++;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [CH_W-1:0] want,
                                      input logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    blur_px_t want;
    if (rst) begin
      frame_w = RST_WIDTH;
      frame_h = RST_HEIGHT;
      in_pos = 0;
      out_pos = 0;
      fail_count = 0;
      mean_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = mean_q.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("frame_done", CH_W'(want.done), CH_W'(frame_done));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_t'(paddr[2]))
          REG_WIDTH:  frame_w = pwdata[FW_W-1:0];
          REG_HEIGHT: frame_h = pwdata[FH_W-1:0];
          default: ;
        endcase
        in_pos = 0;
        out_pos = 0;
      end
      if (in_valid && in_ready) begin
        if (blur_step(mode, {red_in, green_in, blue_in}, want)) mean_q.push_back(want);
      end
    end
    blurred_owed = mean_q.size();
  end

endmodule

/* bench/tb_top.sv */
// testbench top for the 3x3 box blur: clock, reset, register writes and pixel words
// with random gaps on both channels; verdict from the failure count of blur_checker
// depends on bb3_pkg, blur_checker and box_blur_3x3_edge_aware_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bb3_pkg::*;

  localparam int MAX_WIDTH      = 1024;
  localparam int RANDOM_WORDS   = 1050;
  localparam int SETTLE         = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [CH_W-1:0]    red_in;
  logic [CH_W-1:0]    green_in;
  logic [CH_W-1:0]    blue_in;
  logic               out_valid;
  logic               out_ready;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic               frame_done;
  int                 fail_count;
  int                 blurred_owed;

  bit calm;
  bit hold_req;
  int words_sent;
  int cur_w;
  int cur_h;
  int quiet_cycles = 0;

  box_blur_3x3_edge_aware_top #(.MAX_WIDTH(MAX_WIDTH)) uut (.*);

  blur_checker #(.MAX_WIDTH(MAX_WIDTH)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom());
    endcase
  endfunction

  task automatic send_word(input logic m, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic reg_write(input reg_t idx, input logic [PDATA_W-1:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drop valid, wait for every blurred pixel, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (blurred_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input int w_reg, input int h_reg);
    settle();
    reg_write(REG_WIDTH, (PDATA_W'($urandom()) << FW_W) | PDATA_W'(w_reg));
    reg_write(REG_HEIGHT, (PDATA_W'($urandom()) << FH_W) | PDATA_W'(h_reg));
    cur_w = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
    cur_h = (h_reg == 0) ? 1 : h_reg;
  endtask

  // pixels of the frame, optional stray flushes, then words that drain the last row
  task automatic run_pixels(input int count, input bit drain, input bit noisy);
    repeat (count) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        send_word(1'b1, rand_chan(), rand_chan(), rand_chan());
      end
      send_word(1'b0, rand_chan(), rand_chan(), rand_chan());
      words_sent++;
    end
    if (drain) begin
      repeat (cur_w + 1) begin
        send_word(1'($urandom_range(0, 1)), rand_chan(), rand_chan(), rand_chan());
        words_sent++;
      end
    end
  endtask

  initial begin : drain_side
    int gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    mode = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    words_sent = 0;
    cur_w = 1;
    cur_h = 1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero width and height act as a single pixel; the flush ahead of it is dropped
    configure(0, 0);
    send_word(1'b1, '1, '1, '1);
    send_word(1'b0, '1, '1, '1);
    run_pixels(0, 1'b1, 1'b0);
    configure(1, 3);
    run_pixels(3, 1'b1, 1'b1);
    configure(3, 3);
    run_pixels(9, 1'b1, 1'b0);
    // tallest frame and saturated width, both left unfinished
    configure(2, 4095);
    run_pixels(12, 1'b0, 1'b0);
    configure(2047, 2);
    run_pixels(MAX_WIDTH + 6, 1'b0, 1'b0);

    hold_req = 1'b1;
    configure(8, 3);
    run_pixels(24, 1'b1, 1'b1);
    while (words_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      configure(($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 8),
                $urandom_range(0, 6));
      repeat ($urandom_range(1, 3)) run_pixels(cur_w * cur_h, 1'b1, 1'b1);
      if ($urandom_range(0, 4) == 0) run_pixels($urandom_range(1, cur_w * cur_h), 1'b0, 1'b1);
    end

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
